// File: design/spd_pkg.sv
`timescale 1ns / 1ps
// spd_pkg: shared types and constants of the sensor packet deframer
// no dependencies; used by spd_ctrl, spd_datapath and the top level

package spd_pkg;

  // frame start marker ('P')
  localparam logic [7:0] HEAD_BYTE = 8'h50;

  // fixed frame byte positions
  localparam int IDX_NODE     = 1;
  localparam int IDX_FIELD_LO = 8;
  localparam int IDX_FIELD_HI = 24;
  localparam int NUM_FIELD    = IDX_FIELD_HI - IDX_FIELD_LO + 1;

  // earliest resync position after a checksum error
  localparam int RESYNC_FROM = 2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DECIDE
  } spd_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic append;
    logic scan_start;
    logic scan_rd;
    logic drop;
    logic emit;
  } spd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fill_last;
    logic rd_last;
    logic frame_good;
    logic out_free;
  } spd_status_t;

endpackage

// File: design/spd_ctrl.sv
`timescale 1ns / 1ps
// spd_ctrl: controller state machine of the deframer
// depends on spd_pkg; drives spd_datapath through command/status structs

module spd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  spd_pkg::spd_status_t st,
  output spd_pkg::spd_cmd_t    cmd
);

  spd_pkg::spd_state_t state;
  spd_pkg::spd_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      spd_pkg::ST_IDLE: begin
        if (in_valid && st.fill_last) begin
          state_next = spd_pkg::ST_SCAN;
        end
      end
      spd_pkg::ST_SCAN: begin
        if (st.rd_last) begin
          state_next = spd_pkg::ST_FLUSH;
        end
      end
      spd_pkg::ST_FLUSH: begin
        state_next = spd_pkg::ST_DECIDE;
      end
      spd_pkg::ST_DECIDE: begin
        if (!st.frame_good || st.out_free) begin
          state_next = spd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spd_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      spd_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.append     = in_valid;
        cmd.scan_start = in_valid && st.fill_last;
      end
      spd_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      spd_pkg::ST_FLUSH: begin
        cmd = '0;
      end
      spd_pkg::ST_DECIDE: begin
        cmd.drop = !st.frame_good;
        cmd.emit = st.frame_good && st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: design/spd_datapath.sv
`timescale 1ns / 1ps
// spd_datapath: circular frame buffer, scan accumulators and output register
// depends on spd_pkg; controlled by spd_ctrl

module spd_datapath #(
  parameter int PKT_LEN = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spd_pkg::spd_cmd_t    cmd,
  output spd_pkg::spd_status_t st,
  input  logic [7:0]           rx_byte,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [3:0]           node_id,
  output logic [3:0]           key_status,
  output logic [1:0]           lighthouse_id,
  output logic                 data_valid,
  output logic [31:0]          timestamp,
  output logic signed [18:0]   pos_x,
  output logic signed [18:0]   pos_y,
  output logic signed [18:0]   pos_z,
  output logic signed [15:0]   gyro_q_x,
  output logic signed [15:0]   gyro_q_y,
  output logic signed [15:0]   gyro_q_z
);

  localparam int AW = $clog2(PKT_LEN);
  localparam int CW = $clog2(PKT_LEN + 1);
  localparam logic [CW:0]   LEN_W  = (CW + 1)'(PKT_LEN);
  localparam logic [CW-1:0] LEN_C  = CW'(PKT_LEN);
  localparam logic [CW-1:0] LAST_C = CW'(PKT_LEN - 1);
  localparam logic [AW-1:0] LAST_A = AW'(PKT_LEN - 1);

  logic [7:0]    mem [PKT_LEN];
  logic [AW-1:0] base;
  logic [CW-1:0] fill;
  logic [AW-1:0] rd_idx;
  logic [7:0]    rd_data;
  logic          d_vld;
  logic [AW-1:0] d_idx;

  logic [CW-1:0] head0;
  logic [CW-1:0] head2;
  logic [7:0]    sum;
  logic [7:0]    last_byte;
  logic [7:0]    b_node;
  logic [7:0]    cap [spd_pkg::NUM_FIELD];

  logic [CW:0]   wr_sum;
  logic [AW-1:0] wr_addr;
  logic [CW:0]   rd_sum;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] drop_n;
  logic [CW:0]   base_sum;
  logic [AW-1:0] base_next;
  logic [7:0]    b8, b9, b10, b11, b12, b13, b14, b15;
  logic [7:0]    b16, b17, b18, b19, b20, b21, b22, b23, b24;

  // physical addresses, buffer is circular from base
  always_comb begin
    wr_sum = (CW + 1)'(base) + (CW + 1)'(fill);
    if (wr_sum >= LEN_W) begin
      wr_addr = AW'(wr_sum - LEN_W);
    end else begin
      wr_addr = AW'(wr_sum);
    end
    rd_sum = (CW + 1)'(base) + (CW + 1)'(rd_idx);
    if (rd_sum >= LEN_W) begin
      rd_addr = AW'(rd_sum - LEN_W);
    end else begin
      rd_addr = AW'(rd_sum);
    end
  end

  // drop amount: misaligned head first, otherwise resync point
  always_comb begin
    if (head0 != '0) begin
      drop_n = head0;
    end else begin
      drop_n = head2;
    end
    base_sum = (CW + 1)'(base) + (CW + 1)'(drop_n);
    if (base_sum >= LEN_W) begin
      base_next = AW'(base_sum - LEN_W);
    end else begin
      base_next = AW'(base_sum);
    end
  end

  // frame buffer memory
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[wr_addr] <= rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // fill level and buffer start
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      base <= '0;
    end else begin
      priority if (cmd.append) begin
        fill <= fill + CW'(1);
      end else if (cmd.drop) begin
        fill <= fill - drop_n;
        base <= base_next;
      end else if (cmd.emit) begin
        fill <= '0;
      end
    end
  end

  // scan read counter and read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      d_vld  <= 1'b0;
    end else begin
      d_vld <= cmd.scan_rd;
      if (cmd.scan_start) begin
        rd_idx <= '0;
      end else if (cmd.scan_rd && rd_idx != LAST_A) begin
        rd_idx <= rd_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    d_idx <= rd_idx;
  end

  // head search, checksum and field capture over the scan
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      head0 <= LEN_C;
      head2 <= LEN_C;
      sum   <= '0;
    end else if (d_vld) begin
      if (head0 == LEN_C && rd_data == spd_pkg::HEAD_BYTE) begin
        head0 <= CW'(d_idx);
      end
      if (head2 == LEN_C && rd_data == spd_pkg::HEAD_BYTE &&
          d_idx >= AW'(spd_pkg::RESYNC_FROM)) begin
        head2 <= CW'(d_idx);
      end
      if (d_idx == LAST_A) begin
        last_byte <= rd_data;
      end else begin
        sum <= sum + rd_data;
      end
      if (d_idx == AW'(spd_pkg::IDX_NODE)) begin
        b_node <= rd_data;
      end
      for (int k = 0; k < spd_pkg::NUM_FIELD; k++) begin
        if (d_idx == AW'(spd_pkg::IDX_FIELD_LO + k)) begin
          cap[k] <= rd_data;
        end
      end
    end
  end

  // status to controller
  always_comb begin
    st.fill_last  = (fill == LAST_C);
    st.rd_last    = (rd_idx == LAST_A);
    st.frame_good = (head0 == '0) && (sum == last_byte);
    st.out_free   = !out_valid || out_ready;
  end

  // captured bytes by frame position
  assign b8  = cap[0];
  assign b9  = cap[1];
  assign b10 = cap[2];
  assign b11 = cap[3];
  assign b12 = cap[4];
  assign b13 = cap[5];
  assign b14 = cap[6];
  assign b15 = cap[7];
  assign b16 = cap[8];
  assign b17 = cap[9];
  assign b18 = cap[10];
  assign b19 = cap[11];
  assign b20 = cap[12];
  assign b21 = cap[13];
  assign b22 = cap[14];
  assign b23 = cap[15];
  assign b24 = cap[16];

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      node_id       <= b_node[3:0];
      key_status    <= b_node[7:4];
      lighthouse_id <= {1'b0, b24[6]} + 2'd1;
      data_valid    <= b24[7];
      timestamp     <= {b23, b22, b21, b20};
      pos_x         <= {b24[1], b18[1:0], b9, b8};
      pos_y         <= {b24[3], b18[3:2], b11, b10};
      pos_z         <= {b24[5], b18[5:4], b13, b12};
      gyro_q_x      <= {b15, b14};
      gyro_q_y      <= {b17, b16};
      gyro_q_z      <= {b19, b18};
    end
  end

`ifndef SYNTHESIS
  // buffer start stays inside the buffer
  a_base_range: assert property (@(posedge clk) disable iff (rst)
    (CW + 1)'(base) < LEN_W)
    else $error("buffer start out of range");

  // a byte is never appended to a full buffer
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> fill < LEN_C)
    else $error("append into full buffer");

  // a drop or an emit leaves room for the next byte
  a_after_decide: assert property (@(posedge clk) disable iff (rst)
    (cmd.drop || cmd.emit) |=> fill < LEN_C)
    else $error("buffer still full after decision");

  // a result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwritten");

  // an emitted result is presented next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");
`endif

endmodule

// File: design/sensor_packet_deframer_core.sv
`timescale 1ns / 1ps
// sensor_packet_deframer_core: byte-serial deframer for fixed-length sensor packets
// flow: a byte that leaves the buffer short of PKT_LEN is only appended; the byte that
// fills it starts one buffer read per byte for the head search and checksum scan, then
// a read flush and a decision, which holds a good frame while an earlier result waits;
// results appear the cycle after the decision; reset (rst, synchronous) empties the buffer
// depends on spd_pkg, spd_ctrl and spd_datapath

module sensor_packet_deframer_core #(
  parameter int PKT_LEN = 26
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         node_id,
  output logic [3:0]         key_status,
  output logic [1:0]         lighthouse_id,
  output logic               data_valid,
  output logic [31:0]        timestamp,
  output logic signed [18:0] pos_x,
  output logic signed [18:0] pos_y,
  output logic signed [18:0] pos_z,
  output logic signed [15:0] gyro_q_x,
  output logic signed [15:0] gyro_q_y,
  output logic signed [15:0] gyro_q_z
);

  spd_pkg::spd_cmd_t    cmd;
  spd_pkg::spd_status_t st;

  // controller
  spd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  spd_datapath #(
    .PKT_LEN (PKT_LEN)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .rx_byte       (rx_byte),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .node_id       (node_id),
    .key_status    (key_status),
    .lighthouse_id (lighthouse_id),
    .data_valid    (data_valid),
    .timestamp     (timestamp),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .gyro_q_x      (gyro_q_x),
    .gyro_q_y      (gyro_q_y),
    .gyro_q_z      (gyro_q_z)
  );

endmodule
